// ===== sv/bdp_pkg.sv =====
`timescale 1ns / 1ps
package bdp_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned MAG_W  = 63;
  localparam int unsigned CNT_W  = 33;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    OP_CONTROL = 2'd0,
    OP_DIFF    = 2'd1,
    OP_EXTRA   = 2'd2,
    OP_INVALID = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_AWAIT    = 3'd0,
    PH_ADD      = 3'd1,
    PH_COPY     = 3'd2,
    PH_DONE     = 3'd3,
    PH_ERR_ADD  = 3'd4,
    PH_ERR_COPY = 3'd5,
    PH_ERR_BAD  = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_ADD_OVERRUN  = 3'd1,
    ST_COPY_OVERRUN = 3'd2,
    ST_BAD_ORDER    = 3'd3,
    ST_COMPLETE     = 3'd4
  } status_t;

  typedef enum logic {
    REG_OLD_SIZE = 1'b0,
    REG_NEW_SIZE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SIZE_W-1:0] old_image_size;
    logic [SIZE_W-1:0] new_image_size;
  } cfg_t;

  typedef struct packed {
    op_t               operation;
    logic [WORD_W-1:0] add_word;
    logic [WORD_W-1:0] copy_word;
    logic [WORD_W-1:0] seek_word;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] old_byte;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic                     out_valid;
    logic [BYTE_W-1:0]        out_byte;
    logic [SIZE_W-1:0]        out_position;
    logic signed [WORD_W-1:0] next_old_address;
  } result_t;

endpackage

// ===== sv/bdp_core.sv =====
`timescale 1ns / 1ps
module bdp_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  bdp_pkg::item_t   item,
  input  bdp_pkg::cfg_t    cfg,
  output bdp_pkg::result_t result
);
  import bdp_pkg::*;

  phase_t            phase, phase_next, phase_cur;
  logic [CNT_W-1:0]  new_position, new_position_next;
  logic [WORD_W-1:0] old_position, old_position_next;
  logic [CNT_W-1:0]  add_remaining, add_remaining_next;
  logic [CNT_W-1:0]  copy_remaining, copy_remaining_next;
  logic [WORD_W-1:0] seek_pending, seek_pending_next;

  logic [MAG_W-1:0]  am, cm, sm;
  logic              add_neg, copy_neg, seek_neg;
  logic [CNT_W:0]    add_sum;
  logic              add_over;
  logic [CNT_W-1:0]  copy_sat;
  logic [WORD_W-1:0] seek_val;
  logic [CNT_W-1:0]  np_inc, np_eff, cr_eff;
  logic [CNT_W:0]    copy_sum;
  logic              copy_over;
  logic [WORD_W-1:0] old_inc, old_seek, seek_opnd;
  logic              seek_cin;
  logic [CNT_W-1:0]  size_ext;
  logic              old_in_range;
  logic [BYTE_W-1:0] mixed_byte;
  logic              valid;
  logic [BYTE_W-1:0] obyte;
  logic [SIZE_W-1:0] opos;

  // operand decode and shared arithmetic
  always_comb begin
    size_ext  = {1'b0, cfg.new_image_size};
    phase_cur = (phase == PH_AWAIT && new_position >= size_ext) ? PH_DONE : phase;
    am        = item.add_word[MAG_W-1:0];
    cm        = item.copy_word[MAG_W-1:0];
    sm        = item.seek_word[MAG_W-1:0];
    add_neg   = item.add_word[WORD_W-1] && (|am);
    copy_neg  = item.copy_word[WORD_W-1] && (|cm);
    seek_neg  = item.seek_word[WORD_W-1];
    add_sum   = {1'b0, new_position} + {1'b0, am[CNT_W-1:0]};
    add_over  = (|am[MAG_W-1:CNT_W]) || (add_sum > {2'b00, cfg.new_image_size});
    copy_sat  = (|cm[MAG_W-1:CNT_W]) ? {CNT_W{1'b1}} : cm[CNT_W-1:0];
    seek_val  = seek_neg ? (~{1'b0, sm} + 64'd1) : {1'b0, sm};
    np_inc    = new_position + 33'd1;
    np_eff    = (item.operation == OP_DIFF) ? np_inc : new_position;
    cr_eff    = (item.operation == OP_CONTROL) ? copy_sat : copy_remaining;
    copy_sum  = {1'b0, np_eff} + {1'b0, cr_eff};
    copy_over = copy_sum > {2'b00, cfg.new_image_size};
    old_inc   = old_position + 64'd1;
    seek_opnd = (item.operation == OP_CONTROL) ?
                (seek_neg ? ~{1'b0, sm} : {1'b0, sm}) : seek_pending;
    seek_cin  = (item.operation == OP_CONTROL) ? seek_neg : (item.operation == OP_DIFF);
    old_seek  = old_position + seek_opnd + {{(WORD_W-1){1'b0}}, seek_cin};
    old_in_range = (old_position[WORD_W-1:SIZE_W] == '0) &&
                   (old_position[SIZE_W-1:0] < cfg.old_image_size);
    mixed_byte = old_in_range ? (item.data_byte + item.old_byte) : item.data_byte;
  end

  // next state
  always_comb begin
    phase_next          = phase_cur;
    new_position_next   = new_position;
    old_position_next   = old_position;
    add_remaining_next  = add_remaining;
    copy_remaining_next = copy_remaining;
    seek_pending_next   = seek_pending;
    valid               = 1'b0;
    obyte               = '0;
    opos                = '0;
    if (phase_cur == PH_AWAIT || phase_cur == PH_ADD || phase_cur == PH_COPY) begin
      unique case (item.operation)
        OP_CONTROL: begin
          if (phase_cur != PH_AWAIT || add_neg) begin
            phase_next = PH_ERR_BAD;
          end else if (add_over) begin
            phase_next = PH_ERR_ADD;
          end else if (copy_neg) begin
            phase_next = PH_ERR_BAD;
          end else begin
            add_remaining_next  = am[CNT_W-1:0];
            copy_remaining_next = copy_sat;
            seek_pending_next   = seek_val;
            if (|am) begin
              phase_next = PH_ADD;
            end else if (copy_over) begin
              phase_next = PH_ERR_COPY;
            end else if (copy_sat == '0) begin
              old_position_next = old_seek;
              phase_next = (new_position >= size_ext) ? PH_DONE : PH_AWAIT;
            end else begin
              phase_next = PH_COPY;
            end
          end
        end
        OP_DIFF: begin
          if (phase_cur != PH_ADD) begin
            phase_next = PH_ERR_BAD;
          end else begin
            valid              = 1'b1;
            obyte              = mixed_byte;
            opos               = new_position[SIZE_W-1:0];
            new_position_next  = np_inc;
            old_position_next  = old_inc;
            add_remaining_next = add_remaining - 33'd1;
            if (add_remaining == 33'd1) begin
              if (copy_over) begin
                phase_next = PH_ERR_COPY;
              end else if (copy_remaining == '0) begin
                old_position_next = old_seek;
                phase_next = (np_inc >= size_ext) ? PH_DONE : PH_AWAIT;
              end else begin
                phase_next = PH_COPY;
              end
            end
          end
        end
        OP_EXTRA: begin
          if (phase_cur != PH_COPY) begin
            phase_next = PH_ERR_BAD;
          end else begin
            valid               = 1'b1;
            obyte               = item.data_byte;
            opos                = new_position[SIZE_W-1:0];
            new_position_next   = np_inc;
            copy_remaining_next = copy_remaining - 33'd1;
            if (copy_remaining == 33'd1) begin
              old_position_next = old_seek;
              phase_next = (np_inc >= size_ext) ? PH_DONE : PH_AWAIT;
            end
          end
        end
        default: begin
          phase_next = PH_ERR_BAD;
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    result.out_valid        = valid;
    result.out_byte         = obyte;
    result.out_position     = opos;
    result.next_old_address = old_position_next;
    unique case (phase_next)
      PH_DONE:     result.status = ST_COMPLETE;
      PH_ERR_ADD:  result.status = ST_ADD_OVERRUN;
      PH_ERR_COPY: result.status = ST_COPY_OVERRUN;
      PH_ERR_BAD:  result.status = ST_BAD_ORDER;
      default:     result.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_AWAIT;
      new_position   <= '0;
      old_position   <= '0;
      add_remaining  <= '0;
      copy_remaining <= '0;
      seek_pending   <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      new_position   <= new_position_next;
      old_position   <= old_position_next;
      add_remaining  <= add_remaining_next;
      copy_remaining <= copy_remaining_next;
      seek_pending   <= seek_pending_next;
    end
  end

endmodule

// ===== sv/binary_delta_patch_apply_unit.sv =====
`timescale 1ns / 1ps
// a result appears on the master side in the cycle after its request is taken
// throughput: one request per cycle unless the output stalls; all per-item work sits
// between the state registers and the single output register
// s_tready drops only while a result waits in the output register
// reset (rst, synchronous) clears positions, counters, phase and the output valid,
// and sets old_image_size to 0 and new_image_size to 1
module binary_delta_patch_apply_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [207:0] s_tdata,  // add_word, copy_word, seek_word, data_byte, old_byte
  input  logic [1:0]   s_tuser,  // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,  // out_byte, out_position, next_old_address
  output logic [3:0]   m_tuser,  // status, out_valid
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bdp_pkg::*;

  cfg_t     cfg;
  item_t    item;
  result_t  result, result_reg;
  logic     accept;
  logic     m_tvalid_next;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      REG_OLD_SIZE: prdata = cfg.old_image_size;
      REG_NEW_SIZE: prdata = cfg.new_image_size;
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.old_image_size <= 32'd0;
      cfg.new_image_size <= 32'd1;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_OLD_SIZE: cfg.old_image_size <= pwdata;
        REG_NEW_SIZE: cfg.new_image_size <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.operation = op_t'(s_tuser);
    item.add_word  = s_tdata[63:0];
    item.copy_word = s_tdata[127:64];
    item.seek_word = s_tdata[191:128];
    item.data_byte = s_tdata[199:192];
    item.old_byte  = s_tdata[207:200];
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  bdp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_comb begin
    if (accept) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_reg <= result;
    end
  end

  assign m_tdata = {result_reg.next_old_address, result_reg.out_position, result_reg.out_byte};
  assign m_tuser = {result_reg.out_valid, result_reg.status};

endmodule

// ===== sv/bdp_checker.sv =====
`timescale 1ns / 1ps
module bdp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [3:0]   m_tuser
);
  import bdp_pkg::*;

  // a waiting result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // input side only backs up behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");

  // a produced byte comes only with ok, copy overrun or completion
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |->
      m_tuser[2:0] != ST_ADD_OVERRUN && m_tuser[2:0] != ST_BAD_ORDER)
    else $error("byte produced with add overrun or bad order status");

  // byte and position are zero when no byte is produced
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[3] |-> m_tdata[39:0] == 40'd0)
    else $error("stale byte fields without out_valid");

endmodule

bind binary_delta_patch_apply_unit bdp_checker u_bdp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
